// File: hw/rtl/points_to_constraint_step_macros.svh
// ---------------------------------------------------------------------------
// points_to_constraint_step_macros.svh
// Assertion macros for the points-to constraint step block.
// ---------------------------------------------------------------------------
`ifndef POINTS_TO_CONSTRAINT_STEP_MACROS_SVH
`define POINTS_TO_CONSTRAINT_STEP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is held
`define PTCS_ASSERT_IMPLIES(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define PTCS_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define PTCS_ASSERT_IMPLIES(label, clk, rstn, cond, expr)
`define PTCS_ASSERT_NEXT(label, clk, rstn, cond, expr)

`endif

`endif

// File: hw/rtl/ptcs_pkg.sv
// ---------------------------------------------------------------------------
// ptcs_pkg
// Shared constants, types and helpers of the points-to constraint step block.
// ---------------------------------------------------------------------------
package ptcs_pkg;

    localparam int unsigned NUM_VARS = 64;
    localparam int unsigned VAR_W    = 6;
    localparam int unsigned ROW_W    = 64;
    localparam int unsigned IDX_W    = $clog2(NUM_VARS);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VARS - 1);
    localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - NUM_VARS);

    typedef enum logic [2:0] {
        KIND_COPY       = 3'd0,
        KIND_ADDR_OF    = 3'd1,
        KIND_LOAD       = 3'd2,
        KIND_STORE      = 3'd3,
        KIND_STORE_ADDR = 3'd4,
        KIND_LOAD_STORE = 3'd5,
        KIND_NOP        = 3'd6,
        KIND_QUERY      = 3'd7
    } ptcs_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_S,
        ST_RD_D,
        ST_DISPATCH,
        ST_GATHER,
        ST_GATHER_LAST,
        ST_SC_RD,
        ST_SC_WR,
        ST_FIN_RD,
        ST_FIN_CAP,
        ST_DONE
    } ptcs_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ROW_W-1:0] wdata;
    } ptcs_mem_req_t;

    typedef struct packed {
        logic             valid;
        logic             changed;
        logic [ROW_W-1:0] row;
    } ptcs_res_t;

    function automatic logic in_range(input logic [VAR_W-1:0] v);
        return {1'b0, v} < (VAR_W + 1)'(NUM_VARS);
    endfunction

endpackage

// File: hw/rtl/ptcs_mem.sv
// ---------------------------------------------------------------------------
// ptcs_mem
// Points-to matrix: one row per variable, one write and one read port,
// registered read data. Per-row valid bits make every row read as zero
// after reset until it is first written.
// ---------------------------------------------------------------------------
module ptcs_mem
    import ptcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptcs_mem_req_t        req,
    output logic [ROW_W-1:0]     rd_data
);

    logic [ROW_W-1:0] mem_array [NUM_VARS];
    logic [NUM_VARS-1:0] vld_reg;
    logic [ROW_W-1:0] rq_reg;
    logic             rvld_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_array[req.waddr] <= req.wdata;
        end
        rq_reg <= mem_array[req.raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (req.we) begin
                vld_reg[req.waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[req.raddr];
        end
    end

    assign rd_data = rvld_reg ? rq_reg : '0;

endmodule

// File: hw/rtl/ptcs_seq.sv
// ---------------------------------------------------------------------------
// ptcs_seq
// Constraint sequencer: reads the source and destination rows, gathers the
// row-set union for load kinds, then read-modify-writes each target in turn.
// ---------------------------------------------------------------------------
module ptcs_seq
    import ptcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ptcs_kind_t        in_kind,
    input  logic [VAR_W-1:0]  in_dest,
    input  logic [VAR_W-1:0]  in_src,
    input  logic              out_free,
    output ptcs_mem_req_t     mem_req,
    input  logic [ROW_W-1:0]  rd_data,
    output ptcs_res_t         res
);

    ptcs_state_t state_reg, state_next;

    ptcs_kind_t       kind_reg;
    logic [VAR_W-1:0] d_reg;
    logic [VAR_W-1:0] s_reg;
    logic             d_ok_reg;
    logic [ROW_W-1:0] psrc_reg;
    logic [ROW_W-1:0] tgt_reg;
    logic [ROW_W-1:0] val_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] gprev_reg;
    logic             gpend_reg;
    logic             changed_reg;
    logic [ROW_W-1:0] row_reg;

    logic [IDX_W-1:0] idx_inc;
    logic [ROW_W-1:0] merged;
    logic             is_gather;
    logic             is_scatter_set;

    assign idx_inc        = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign merged         = (rd_data | val_reg) & ROW_MASK;
    assign is_gather      = (kind_reg == KIND_LOAD) || (kind_reg == KIND_LOAD_STORE);
    assign is_scatter_set = (kind_reg == KIND_STORE) || (kind_reg == KIND_STORE_ADDR)
                         || (kind_reg == KIND_LOAD_STORE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_kind != KIND_NOP && in_kind != KIND_QUERY
                                  && in_range(in_dest) && in_range(in_src))
                                 ? ST_RD_S : ST_FIN_RD;
                end
            end
            ST_RD_S:        state_next = ST_RD_D;
            ST_RD_D:        state_next = ST_DISPATCH;
            ST_DISPATCH:    state_next = is_gather ? ST_GATHER : ST_SC_RD;
            ST_GATHER:      state_next = (idx_reg == LAST_IDX) ? ST_GATHER_LAST : ST_GATHER;
            ST_GATHER_LAST: state_next = ST_SC_RD;
            ST_SC_RD: begin
                if (tgt_reg[idx_reg]) begin
                    state_next = ST_SC_WR;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_SC_WR:       state_next = (idx_reg == LAST_IDX) ? ST_FIN_RD : ST_SC_RD;
            ST_FIN_RD:      state_next = ST_FIN_CAP;
            ST_FIN_CAP:     state_next = ST_DONE;
            ST_DONE:        state_next = out_free ? ST_IDLE : ST_DONE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        mem_req.raddr = idx_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = merged;
        res.valid     = 1'b0;
        res.changed   = changed_reg;
        res.row       = row_reg;
        unique case (state_reg)
            ST_IDLE:   in_ready      = aresetn;
            ST_RD_S:   mem_req.raddr = s_reg[IDX_W-1:0];
            ST_RD_D:   mem_req.raddr = d_reg[IDX_W-1:0];
            ST_SC_WR:  mem_req.we    = 1'b1;
            ST_FIN_RD: mem_req.raddr = d_reg[IDX_W-1:0];
            ST_DONE:   res.valid     = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            changed_reg <= 1'b0;
            gpend_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        kind_reg    <= in_kind;
                        d_reg       <= in_dest;
                        s_reg       <= in_src;
                        d_ok_reg    <= in_range(in_dest);
                        changed_reg <= 1'b0;
                    end
                end
                ST_RD_D: psrc_reg <= rd_data;
                ST_DISPATCH: begin
                    // rd_data holds the destination row here
                    tgt_reg   <= is_scatter_set ? rd_data : (ROW_W'(1) << d_reg);
                    idx_reg   <= '0;
                    gpend_reg <= 1'b0;
                    if (is_gather) begin
                        val_reg <= '0;
                    end else if (kind_reg == KIND_ADDR_OF || kind_reg == KIND_STORE_ADDR) begin
                        val_reg <= (ROW_W'(1) << s_reg) & ROW_MASK;
                    end else begin
                        val_reg <= psrc_reg;
                    end
                end
                ST_GATHER: begin
                    if (gpend_reg && psrc_reg[gprev_reg]) begin
                        val_reg <= val_reg | rd_data;
                    end
                    gprev_reg <= idx_reg;
                    gpend_reg <= 1'b1;
                    idx_reg   <= idx_inc;
                end
                ST_GATHER_LAST: begin
                    if (psrc_reg[gprev_reg]) begin
                        val_reg <= val_reg | rd_data;
                    end
                    gpend_reg <= 1'b0;
                end
                ST_SC_RD: begin
                    if (!tgt_reg[idx_reg]) begin
                        idx_reg <= idx_inc;
                    end
                end
                ST_SC_WR: begin
                    if (merged != rd_data) begin
                        changed_reg <= 1'b1;
                    end
                    idx_reg <= idx_inc;
                end
                ST_FIN_CAP: row_reg <= d_ok_reg ? (rd_data & ROW_MASK) : '0;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/points_to_constraint_step.sv
// ---------------------------------------------------------------------------
// points_to_constraint_step
// One inclusion-constraint step over a 64x64 points-to bit matrix.
// ---------------------------------------------------------------------------
// The s_ channel takes one constraint request: the kind on s_tuser, the
// destination and source variables on s_tdata. The m_ channel returns one
// result per request: the changed flag and the destination row after the
// step. Software reissues constraints until no step reports a change.
// An accepted request passes these steps in order: source and destination
// row reads, dispatch, for load kinds a row-union walk over all NUM_VARS
// rows, a target walk over all NUM_VARS rows with a write step for each
// target row that is rewritten, then the final destination row read and
// capture and the result hand-off; nop, query and out-of-range requests go
// straight to the final read. All row reads share the single matrix read
// port. One request is in work at a time, and the next is taken the cycle
// after a hand-off. Reset clears the matrix at once through per-row valid
// bits. A stalled receiver holds the result in the output register; the next
// request is still worked and its result waits in the sequencer until the
// register frees.
// ---------------------------------------------------------------------------
`include "points_to_constraint_step_macros.svh"

module points_to_constraint_step
    import ptcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] dest_var, [11:6] src_var, [15:12] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] changed, [64:1] row_bits, [71:65] zero
);

    ptcs_mem_req_t    mem_req;
    logic [ROW_W-1:0] rd_data;
    ptcs_res_t        res;

    logic             m_tvalid_reg;
    logic             changed_reg;
    logic [ROW_W-1:0] row_reg;
    logic             out_free;
    logic             res_load;

    // the output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_load = res.valid && out_free;

    // matrix storage
    ptcs_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // constraint sequencer
    ptcs_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (ptcs_kind_t'(s_tuser)),
        .in_dest  (s_tdata[5:0]),
        .in_src   (s_tdata[11:6]),
        .out_free (out_free),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .res      (res)
    );

    // output register: hold while stalled, advance on a new result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            changed_reg <= res.changed;
            row_reg     <= res.row;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, row_reg, changed_reg};

    // an accepted request leaves the sequencer busy in the next cycle
    `PTCS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a loaded result shows up on the output in the next cycle
    `PTCS_ASSERT_NEXT(a_result_shows, aclk, aresetn, res_load, m_tvalid)
    // an idle sequencer has no result pending
    `PTCS_ASSERT_IMPLIES(a_idle_no_result, aclk, aresetn, s_tready, !res.valid)

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: points_to_constraint_step testbench
// Sends inclusion-constraint requests over the s_ stream and checks every
// result from the m_ stream against a shadow copy of the points-to matrix.
// ----------------------------------------------------------------------------
module tb_top
    import ptcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_REQUESTS = 1330;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES    = 160;
    localparam int unsigned HOLDOFF_CYCLES  = 400;
    localparam int unsigned HOLDOFF_AT      = 40;

    // One expected result: changed flag and destination row after the step.
    typedef struct packed {
        logic             changed;
        logic [ROW_W-1:0] row;
    } row_result_t;

    // Shadow of the points-to matrix plus the queue of results still owed.
    class points_to_shadow;
        logic [ROW_W-1:0] rows [NUM_VARS];
        logic [ROW_W-1:0] frozen [NUM_VARS];
        row_result_t      owed_results [$];
        int unsigned      mismatches;

        function new();
            foreach (rows[i]) rows[i] = '0;
            mismatches = 0;
        endfunction

        // union of the frozen rows selected by set
        function logic [ROW_W-1:0] union_rows(logic [ROW_W-1:0] set);
            logic [ROW_W-1:0] acc;
            acc = '0;
            for (int x = 0; x < NUM_VARS; x++)
                if (set[x]) acc |= frozen[x];
            return acc;
        endfunction

        // Apply one accepted request to the shadow and queue its result.
        function void note_request(ptcs_kind_t kind, logic [VAR_W-1:0] dest,
                                   logic [VAR_W-1:0] src);
            logic [ROW_W-1:0] targets;
            logic [ROW_W-1:0] addend;
            logic             dest_ok;
            logic             src_ok;
            row_result_t      res;
            targets = '0;
            addend  = '0;
            dest_ok = int'(dest) < int'(NUM_VARS);
            src_ok  = int'(src) < int'(NUM_VARS);
            res.changed = 1'b0;
            frozen = rows;
            if (kind <= KIND_LOAD_STORE && dest_ok && src_ok) begin
                case (kind)
                    KIND_COPY:       rows[dest] |= frozen[src];
                    KIND_ADDR_OF:    rows[dest] |= ROW_W'(1) << src;
                    KIND_LOAD:       rows[dest] |= union_rows(frozen[src]);
                    KIND_STORE: begin
                        targets = frozen[dest];
                        addend  = frozen[src];
                    end
                    KIND_STORE_ADDR: begin
                        targets = frozen[dest];
                        addend  = ROW_W'(1) << src;
                    end
                    default: begin
                        targets = frozen[dest];
                        addend  = union_rows(frozen[src]);
                    end
                endcase
                for (int x = 0; x < NUM_VARS; x++) begin
                    if (targets[x]) rows[x] |= addend;
                    rows[x] &= ROW_MASK;
                    if (rows[x] != frozen[x]) res.changed = 1'b1;
                end
            end
            res.row = dest_ok ? (rows[dest] & ROW_MASK) : '0;
            owed_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(logic changed, logic [ROW_W-1:0] row);
            row_result_t want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, changed=%0b row=%h", $time, changed, row);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (changed !== want.changed) begin
                $display("%0t: changed mismatch, expected %0b actual %0b",
                         $time, want.changed, changed);
                mismatches++;
            end
            if (row !== want.row) begin
                $display("%0t: row_bits mismatch, expected %h actual %h",
                         $time, want.row, row);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [5:0] dest_var, [11:6] src_var, [15:12] zero
    logic [2:0]  s_tuser;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [0] changed, [64:1] row_bits, [71:65] zero

    points_to_shadow shadow = new();
    int unsigned     requests_sent;
    int unsigned     results_seen;
    int unsigned     idle_cycles;

    points_to_constraint_step u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Draw a random wait; every fourth block of 64 runs with no waits.
    function automatic int unsigned draw_wait(int unsigned count, int unsigned phase);
        if (((count / 64) % 4) == phase) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one request, hold it until accepted, then record it in the shadow.
    task automatic send_request(ptcs_kind_t kind, logic [VAR_W-1:0] dest,
                                logic [VAR_W-1:0] src);
        int unsigned gap;
        gap = draw_wait(requests_sent, 1);
        if (gap > 0) begin
            // drop valid only when a gap follows, never lower and raise in one step
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, src, dest};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shadow.note_request(kind, dest, src);
        requests_sent++;
    endtask

    // Pick a kind with most weight on the walking kinds (load and store).
    function automatic ptcs_kind_t draw_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) return KIND_ADDR_OF;
        if (roll < 26) return KIND_COPY;
        if (roll < 41) return KIND_LOAD;
        if (roll < 56) return KIND_STORE;
        if (roll < 69) return KIND_STORE_ADDR;
        if (roll < 83) return KIND_LOAD_STORE;
        if (roll < 91) return KIND_QUERY;
        return KIND_NOP;
    endfunction

    // Receiver: random stalls, one long hold-off, check every result.
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(results_seen, 2);
            if (results_seen == HOLDOFF_AT) stall = HOLDOFF_CYCLES;
            if (stall > 0) begin
                // hold ready low so the block fills up and stalls its input
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            shadow.check_result(m_tdata[0], m_tdata[64:1]);
            results_seen++;
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, shadow.owed_results.size());
            $display("points_to_constraint_step verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned      hi;
        logic [VAR_W-1:0] dest;
        logic [VAR_W-1:0] src;
        requests_sent = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_NOP;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty rows, field extremes, every kind, self references.
        send_request(KIND_QUERY,      6'd0,  6'd0);
        send_request(KIND_QUERY,      6'd63, 6'd63);
        send_request(KIND_ADDR_OF,    6'd0,  6'd63);
        send_request(KIND_ADDR_OF,    6'd63, 6'd0);
        send_request(KIND_ADDR_OF,    6'd1,  6'd1);
        send_request(KIND_ADDR_OF,    6'd2,  6'd63);
        send_request(KIND_COPY,       6'd3,  6'd0);
        send_request(KIND_COPY,       6'd63, 6'd63);
        send_request(KIND_COPY,       6'd4,  6'd2);
        send_request(KIND_LOAD,       6'd5,  6'd4);
        send_request(KIND_STORE,      6'd0,  6'd1);
        send_request(KIND_STORE_ADDR, 6'd1,  6'd0);
        send_request(KIND_LOAD_STORE, 6'd63, 6'd1);
        send_request(KIND_LOAD,       6'd1,  6'd1);
        send_request(KIND_STORE,      6'd1,  6'd1);
        send_request(KIND_LOAD_STORE, 6'd1,  6'd1);
        send_request(KIND_NOP,        6'd0,  6'd0);
        send_request(KIND_NOP,        6'd63, 6'd63);
        send_request(KIND_QUERY,      6'd1,  6'd63);
        send_request(KIND_ADDR_OF,    6'd63, 6'd63);
        send_request(KIND_STORE_ADDR, 6'd63, 6'd62);
        send_request(KIND_STORE,      6'd0,  6'd1);
        send_request(KIND_QUERY,      6'd63, 6'd0);

        // Random: widen the variable window slowly so the sets keep growing
        // over the whole run; a few requests use any index at all.
        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
            hi = 7 + (i * 56) / RANDOM_REQUESTS;
            if ($urandom_range(0, 99) < 5) begin
                dest = VAR_W'($urandom);
                src  = VAR_W'($urandom);
                send_request(ptcs_kind_t'($urandom_range(0, 7)), dest, src);
            end else begin
                dest = VAR_W'($urandom_range(0, hi));
                src  = VAR_W'($urandom_range(0, hi));
                send_request(draw_kind(), dest, src);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        while (shadow.owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.owed_results.size() == 0) begin
            $display("points_to_constraint_step verification clean");
        end else begin
            $display("points_to_constraint_step verification failed");
        end
        $finish;
    end

endmodule
